>>> sv/event_report_rate_limiter_assert.svh
// Assertion macros for the event report rate limiter.
`ifndef EVENT_REPORT_RATE_LIMITER_ASSERT_SVH
`define EVENT_REPORT_RATE_LIMITER_ASSERT_SVH

// Checked only outside reset.
`define ERL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define ERL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/erl_pkg.sv
// Shared types and constants of the event report rate limiter.
package erl_pkg;

    localparam int NUM_CODES_DEF    = 32;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int FIFO_DEPTH       = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMM_MASK  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FAULT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RECOVERED = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_A    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_B    = 3'd6;

    localparam logic [31:0] INTERVAL_RST  = 32'd1000000;
    localparam logic [4:0]  MAX_CODE_RST  = 5'd31;
    localparam logic [31:0] IMM_MASK_RST  = 32'd0;
    localparam logic [7:0]  FAULT_RST     = 8'd0;
    localparam logic [7:0]  RECOVERED_RST = 8'd0;
    localparam logic [7:0]  CHAN_A_RST    = 8'd1;
    localparam logic [7:0]  CHAN_B_RST    = 8'd2;

    localparam logic [1:0] HEALTH_UNKNOWN = 2'd0;
    localparam logic [1:0] HEALTH_OK      = 2'd1;
    localparam logic [1:0] HEALTH_FAULT   = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  channel_b_id;
        logic [7:0]  channel_a_id;
        logic [7:0]  recovered_code;
        logic [7:0]  fault_code;
        logic [31:0] immediate_mask;
        logic [4:0]  max_code;
    } t_erl_cfg;

    typedef struct packed {
        logic        immediate;
        logic [31:0] event_time;
        logic [1:0]  health_a;
        logic [1:0]  health_b;
        logic        health_changed;
    } t_erl_cmd;

    typedef struct packed {
        logic        seen;
        logic [31:0] last_time;
        logic [31:0] count;
    } t_erl_entry;

    typedef struct packed {
        logic        health_changed;
        logic [1:0]  health_b;
        logic [1:0]  health_a;
        logic [31:0] suppressed_total;
        logic        summary_valid;
        logic        report;
    } t_erl_result;

endpackage

>>> sv/event_report_rate_limiter.sv
// An accepted event passes through the command queue, the command and table read registers and the
// result register. The table engine takes one event at a time: it reads the entry in the idle state
// and writes it back in the execute state. A command queue of FIFO_DEPTH entries lets the input run
// ahead of a stalled output. Reset is synchronous, active low; afterwards a clearing pass zeroes all
// NUM_CODES * NUM_CHANNELS table entries (128 by default), and no event is accepted until it ends.
`include "event_report_rate_limiter_assert.svh"

module event_report_rate_limiter
    import erl_pkg::*;
#(
    parameter int NUM_CODES    = NUM_CODES_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // event_code [7:0], channel_num [15:8], event_time [47:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // report [0], summary_valid [1], suppressed_total [33:2], health_a [35:34],
    // health_b [37:36], health_changed [38], zero [39]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int DEPTH  = NUM_CODES * NUM_CHANNELS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMD_W  = $bits(t_erl_cmd);
    localparam int FIFO_W = CMD_W + IDX_W;

    t_erl_cfg          r_cfg;
    logic [31:0]       r_interval;
    logic              w_push, w_full, w_pop, w_q_valid, w_clearing, w_blocked;
    t_erl_cmd          w_cmd, w_q_cmd;
    logic [IDX_W-1:0]  w_idx, w_q_idx;
    logic [FIFO_W-1:0] w_q_data;
    t_erl_result       w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval           <= INTERVAL_RST;
            r_cfg.max_code       <= MAX_CODE_RST;
            r_cfg.immediate_mask <= IMM_MASK_RST;
            r_cfg.fault_code     <= FAULT_RST;
            r_cfg.recovered_code <= RECOVERED_RST;
            r_cfg.channel_a_id   <= CHAN_A_RST;
            r_cfg.channel_b_id   <= CHAN_B_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_INTERVAL:  r_interval           <= i_cfg_wdata;
                REG_MAX_CODE:  r_cfg.max_code       <= i_cfg_wdata[4:0];
                REG_IMM_MASK:  r_cfg.immediate_mask <= i_cfg_wdata;
                REG_FAULT:     r_cfg.fault_code     <= i_cfg_wdata[7:0];
                REG_RECOVERED: r_cfg.recovered_code <= i_cfg_wdata[7:0];
                REG_CHAN_A:    r_cfg.channel_a_id   <= i_cfg_wdata[7:0];
                REG_CHAN_B:    r_cfg.channel_b_id   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign w_blocked = w_full || w_clearing;

    erl_front #(
        .NUM_CODES    (NUM_CODES),
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_blocked (w_blocked),
        .o_push    (w_push),
        .o_cmd     (w_cmd),
        .o_idx     (w_idx)
    );

    erl_fifo #(
        .WIDTH (FIFO_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_cmd, w_idx}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_cmd = w_q_data[FIFO_W-1:IDX_W];
    assign w_q_idx = w_q_data[IDX_W-1:0];

    erl_back #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_interval  (r_interval),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .i_idx       (w_q_idx),
        .o_cmd_pop   (w_pop),
        .o_clearing  (w_clearing),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {1'b0, w_result};

    `ERL_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> w_clearing, "table clear did not start after reset")
    `ERL_ASSERT(a_no_accept_in_clear, w_clearing |-> !s_axis_tready, "event accepted during table clear")
    `ERL_ASSERT(a_summary_has_report, (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0], "summary without report")
    `ERL_ASSERT(a_total_zero, (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[33:2] == 32'd0), "suppressed total nonzero without summary")

endmodule

>>> sv/erl_fifo.sv
// Small command queue between the classifier and the table engine.
module erl_fifo
    import erl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/erl_front.sv
// Front end: accepts events, classifies them and updates the link health states.
module erl_front
    import erl_pkg::*;
#(
    parameter int NUM_CODES    = NUM_CODES_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_erl_cfg             i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_blocked,
    output logic                 o_push,
    output t_erl_cmd             o_cmd,
    output logic [IDX_W-1:0]     o_idx
);

    logic [7:0]  w_code, w_chan;
    logic [31:0] w_ts;
    logic [15:0] w_lin;
    logic        w_immediate, w_is_fault, w_is_rec, w_changed;
    logic [1:0]  r_health_a, r_health_b, n_health_a, n_health_b, w_new;

    assign w_code = i_data[7:0];
    assign w_chan = i_data[15:8];
    assign w_ts   = i_data[47:16];

    assign o_ready = !i_blocked;
    assign o_push  = i_valid && o_ready;

    // Codes 32 and up have no mask bit.
    assign w_immediate = (w_code[4:0] > i_cfg.max_code) || (w_code[7:5] != 3'd0) ||
                         (16'(w_code) >= 16'(NUM_CODES)) ||
                         (16'(w_chan) >= 16'(NUM_CHANNELS)) ||
                         (i_cfg.immediate_mask[w_code[4:0]] && (w_code[7:5] == 3'd0));

    assign w_lin = 16'(w_code) * 16'(NUM_CHANNELS) + 16'(w_chan);
    assign o_idx = w_lin[IDX_W-1:0];

    assign w_is_fault = (w_code == i_cfg.fault_code);
    assign w_is_rec   = (w_code == i_cfg.recovered_code);
    assign w_new      = w_is_fault ? HEALTH_FAULT : HEALTH_OK;

    // Channel A takes precedence when both ids match.
    always_comb begin
        n_health_a = r_health_a;
        n_health_b = r_health_b;
        w_changed  = 1'b0;
        if (w_is_fault || w_is_rec) begin
            if (w_chan == i_cfg.channel_a_id) begin
                n_health_a = w_new;
                w_changed  = 1'b1;
            end else if (w_chan == i_cfg.channel_b_id) begin
                n_health_b = w_new;
                w_changed  = 1'b1;
            end
        end
    end

    assign o_cmd.immediate      = w_immediate;
    assign o_cmd.event_time     = w_ts;
    assign o_cmd.health_a       = n_health_a;
    assign o_cmd.health_b       = n_health_b;
    assign o_cmd.health_changed = w_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_health_a <= HEALTH_UNKNOWN;
            r_health_b <= HEALTH_UNKNOWN;
        end else if (o_push) begin
            r_health_a <= n_health_a;
            r_health_b <= n_health_b;
        end
    end

endmodule

>>> sv/erl_back.sv
// Back end: per-pair table read-modify-write, clearing pass and result register.
module erl_back
    import erl_pkg::*;
#(
    parameter int DEPTH = NUM_CODES_DEF * NUM_CHANNELS_DEF,
    parameter int IDX_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_interval,
    input  logic             i_cmd_valid,
    input  t_erl_cmd         i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_cmd_pop,
    output logic             o_clearing,
    output logic             o_valid,
    input  logic             i_ready,
    output t_erl_result      o_result
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_clr_idx, r_idx, w_rd_addr, w_wr_addr;
    t_erl_cmd         r_cmd;
    t_erl_entry       r_mem [DEPTH];
    t_erl_entry       r_rd, w_wr_data;
    t_erl_result      r_out, n_out;
    logic             r_out_valid;
    logic             w_we, w_upd, w_take, w_due;
    logic [31:0]      w_elapsed;

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_cmd_pop  = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    assign w_take    = (r_state == ST_EXEC) && (!r_out_valid || i_ready);
    assign w_rd_addr = (r_state == ST_IDLE) ? i_idx : r_idx;
    assign w_elapsed = r_cmd.event_time - r_rd.last_time;
    assign w_due     = (w_elapsed >= i_interval);

    always_comb begin
        w_upd     = 1'b0;
        w_wr_data = r_rd;
        n_out.report           = 1'b0;
        n_out.summary_valid    = 1'b0;
        n_out.suppressed_total = '0;
        n_out.health_a         = r_cmd.health_a;
        n_out.health_b         = r_cmd.health_b;
        n_out.health_changed   = r_cmd.health_changed;
        if (r_cmd.immediate) begin
            n_out.report = 1'b1;
        end else if (!r_rd.seen) begin
            n_out.report        = 1'b1;
            w_wr_data.seen      = 1'b1;
            w_wr_data.last_time = r_cmd.event_time;
            w_upd               = 1'b1;
        end else if (w_due) begin
            n_out.report           = 1'b1;
            n_out.summary_valid    = (r_rd.count != '0);
            n_out.suppressed_total = r_rd.count;
            w_wr_data.count        = '0;
            w_wr_data.last_time    = r_cmd.event_time;
            w_upd                  = 1'b1;
        end else if (r_rd.count != COUNT_MAX) begin
            w_wr_data.count = r_rd.count + 32'd1;
            w_upd           = 1'b1;
        end
        if (r_state == ST_CLEAR) begin
            w_we      = 1'b1;
            w_wr_addr = r_clr_idx;
            w_wr_data = '0;
        end else begin
            w_we      = w_take && w_upd;
            w_wr_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_idx <= i_idx;
            r_cmd <= i_cmd;
        end
        if (w_take) begin
            r_out <= n_out;
        end
    end

endmodule

>>> verif/event_report_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every report verdict of the rate limiter and compares it.
module event_report_checker
    import erl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ev_valid,
    input  logic                  i_ev_ready,
    // event_code [7:0], channel_num [15:8], event_time [47:16]
    input  logic [IN_DATA_W-1:0]  i_ev_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // report [0], summary_valid [1], suppressed_total [33:2], health_a [35:34],
    // health_b [37:36], health_changed [38], zero [39]
    input  logic [OUT_DATA_W-1:0] i_res_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int NUM_PAIRS = NUM_CODES_DEF * NUM_CHANNELS_DEF;

    logic [31:0] interval_us;
    logic [4:0]  max_code;
    logic [31:0] immediate_mask;
    logic [7:0]  fault_code;
    logic [7:0]  recovered_code;
    logic [7:0]  chan_a_id;
    logic [7:0]  chan_b_id;

    logic        pair_seen [NUM_PAIRS];
    logic [31:0] pair_last [NUM_PAIRS];
    logic [31:0] pair_held [NUM_PAIRS];
    logic [1:0]  health_a;
    logic [1:0]  health_b;

    t_erl_result expected_verdicts[$];
    int          error_count;

    task automatic reset_model;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            pair_seen[i] = 1'b0;
            pair_last[i] = '0;
            pair_held[i] = '0;
        end
        health_a       = HEALTH_UNKNOWN;
        health_b       = HEALTH_UNKNOWN;
        interval_us    = INTERVAL_RST;
        max_code       = MAX_CODE_RST;
        immediate_mask = IMM_MASK_RST;
        fault_code     = FAULT_RST;
        recovered_code = RECOVERED_RST;
        chan_a_id      = CHAN_A_RST;
        chan_b_id      = CHAN_B_RST;
    endtask

    // Updates the pair table and health states for one event and returns its verdict.
    function automatic t_erl_result predict_verdict(input logic [7:0] code,
                                                    input logic [7:0] chan,
                                                    input logic [31:0] ts);
        t_erl_result v;
        logic        bypass;
        logic        hit;
        logic [1:0]  hval;
        logic [31:0] elapsed;
        int          idx;
        v = '0;
        hval = HEALTH_UNKNOWN;
        bypass = (code > {3'b000, max_code}) || (code >= NUM_CODES_DEF) ||
                 (chan >= NUM_CHANNELS_DEF) || (code < 32 && immediate_mask[code[4:0]]);
        if (bypass) begin
            v.report = 1'b1;
        end else begin
            idx = int'(code) * NUM_CHANNELS_DEF + int'(chan);
            elapsed = ts - pair_last[idx];
            if (!pair_seen[idx]) begin
                pair_seen[idx] = 1'b1;
                pair_last[idx] = ts;
                v.report = 1'b1;
            end else if (elapsed >= interval_us) begin
                if (pair_held[idx] != 0) begin
                    v.summary_valid    = 1'b1;
                    v.suppressed_total = pair_held[idx];
                end
                pair_held[idx] = '0;
                pair_last[idx] = ts;
                v.report = 1'b1;
            end else if (pair_held[idx] != COUNT_MAX) begin
                pair_held[idx] = pair_held[idx] + 1;
            end
        end
        // The fault code takes precedence when both codes are equal.
        hit = 1'b1;
        if (code == fault_code) begin
            hval = HEALTH_FAULT;
        end else if (code == recovered_code) begin
            hval = HEALTH_OK;
        end else begin
            hit = 1'b0;
        end
        // With equal channel ids only channel A is updated.
        if (hit) begin
            if (chan == chan_a_id) begin
                health_a = hval;
            end else if (chan == chan_b_id) begin
                health_b = hval;
            end else begin
                hit = 1'b0;
            end
        end
        v.health_changed = hit;
        v.health_a       = health_a;
        v.health_b       = health_b;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_erl_result got;
        t_erl_result want;
        if (!i_rst_n) begin
            reset_model();
            expected_verdicts.delete();
            error_count = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = t_erl_result'(i_res_data[OUT_DATA_W-2:0]);
                if (expected_verdicts.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("result transaction with no pending event: %h", i_res_data);
                    end
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.report !== want.report ||
                        got.summary_valid !== want.summary_valid ||
                        got.suppressed_total !== want.suppressed_total ||
                        got.health_a !== want.health_a ||
                        got.health_b !== want.health_b ||
                        got.health_changed !== want.health_changed ||
                        i_res_data[OUT_DATA_W-1] !== 1'b0) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("want rpt=%0d sv=%0d tot=%0d ha=%0d hb=%0d chg=%0d",
                                     want.report, want.summary_valid, want.suppressed_total,
                                     want.health_a, want.health_b, want.health_changed);
                            $display("got  rpt=%0d sv=%0d tot=%0d ha=%0d hb=%0d chg=%0d pad=%0d",
                                     got.report, got.summary_valid, got.suppressed_total,
                                     got.health_a, got.health_b, got.health_changed,
                                     i_res_data[OUT_DATA_W-1]);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_INTERVAL:  interval_us    = i_cfg_wdata;
                    REG_MAX_CODE:  max_code       = i_cfg_wdata[4:0];
                    REG_IMM_MASK:  immediate_mask = i_cfg_wdata;
                    REG_FAULT:     fault_code     = i_cfg_wdata[7:0];
                    REG_RECOVERED: recovered_code = i_cfg_wdata[7:0];
                    REG_CHAN_A:    chan_a_id      = i_cfg_wdata[7:0];
                    REG_CHAN_B:    chan_b_id      = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_ev_valid && i_ev_ready) begin
                expected_verdicts.push_back(predict_verdict(i_ev_data[7:0], i_ev_data[15:8],
                                                            i_ev_data[47:16]));
            end
        end
        o_pending <= expected_verdicts.size();
        o_errors  <= error_count;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the event report rate limiter: clock, reset, stimulus and verdict.
module testbench;
    import erl_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int pending;
    int errors;
    int cycles;
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;

    // Stimulus-side copy of the settings, used only to aim timestamps and health events.
    logic [31:0] cur_interval;
    logic [7:0]  cur_fault;
    logic [7:0]  cur_rec;
    logic [7:0]  cur_a;
    logic [7:0]  cur_b;
    logic [31:0] ts_now;

    event_report_rate_limiter DUT (.*);

    event_report_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (s_axis_tvalid),
        .i_ev_ready  (s_axis_tready),
        .i_ev_data   (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= 29);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_event(input logic [7:0] code, input logic [7:0] chan,
                              input logic [31:0] ts);
        while (tx_idle_en && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {16'($urandom), $urandom};
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, chan, code};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Upper bits of narrow registers carry junk, which the block must drop.
    task automatic program_limits(input logic [31:0] interval, input logic [4:0] max_c,
                                  input logic [31:0] mask, input logic [7:0] fault,
                                  input logic [7:0] rec, input logic [7:0] a,
                                  input logic [7:0] b);
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_MAX_CODE, {27'($urandom), max_c});
        write_reg(REG_IMM_MASK, mask);
        write_reg(REG_FAULT, {24'($urandom), fault});
        write_reg(REG_RECOVERED, {24'($urandom), rec});
        write_reg(REG_CHAN_A, {24'($urandom), a});
        write_reg(REG_CHAN_B, {24'($urandom), b});
        write_reg(REG_UNUSED, $urandom);
        i_cfg_we     <= 1'b0;
        cur_interval = interval;
        cur_fault    = fault;
        cur_rec      = rec;
        cur_a        = a;
        cur_b        = b;
    endtask

    // Mostly a few busy pairs with time stepping near the interval, some health
    // events, some out-of-range channels and some fully random noise.
    task automatic send_random_item;
        logic [7:0]  code;
        logic [7:0]  chan;
        int          r;
        r = $urandom_range(99);
        if (r < 8) begin
            send_event(8'($urandom), 8'($urandom), $urandom);
        end else begin
            if (r < 20) begin
                code = $urandom_range(1) ? cur_fault : cur_rec;
                case ($urandom_range(2))
                    0:       chan = cur_a;
                    1:       chan = cur_b;
                    default: chan = 8'($urandom_range(7));
                endcase
            end else begin
                if ($urandom_range(4) == 0) begin
                    code = 8'($urandom_range(40));
                end else begin
                    code = 8'($urandom_range(3));
                end
                if (r < 26) begin
                    chan = 8'($urandom_range(255, NUM_CHANNELS_DEF));
                end else begin
                    chan = 8'($urandom_range(NUM_CHANNELS_DEF - 1));
                end
            end
            if ($urandom_range(19) == 0) begin
                ts_now = ts_now + $urandom;
            end else begin
                ts_now = ts_now + $urandom_range(cur_interval / 10 + 1);
            end
            send_event(code, chan, ts_now);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        cur_interval  = INTERVAL_RST;
        cur_fault     = FAULT_RST;
        cur_rec       = RECOVERED_RST;
        cur_a         = CHAN_A_RST;
        cur_b         = CHAN_B_RST;
        ts_now        = 32'hFFFF_FF00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: fault and recovered codes are equal, so fault wins.
        send_event(8'd0, 8'd1, 32'd0);
        send_event(8'd0, 8'd2, 32'd5);
        send_event(8'd3, 8'd0, 32'hFFFF_FFF0);
        send_event(8'd3, 8'd0, 32'h0000_0010);
        send_event(8'd3, 8'd0, 32'hFFFF_FFF0 + 32'd1000000);
        send_event(8'd255, 8'd255, 32'hFFFF_FFFF);
        send_event(8'd31, 8'd3, 32'd0);
        send_event(8'd31, 8'd3, 32'd999999);
        send_event(8'd32, 8'd0, 32'd1);
        send_event(8'd1, 8'd4, 32'd2);
        drain_results;

        // Zero interval, narrow code range, masked code, equal channel ids.
        program_limits(32'd0, 5'd2, 32'h0000_0002, 8'd5, 8'd6, 8'd3, 8'd3);
        send_event(8'd1, 8'd0, 32'd3);
        send_event(8'd2, 8'd0, 32'd7);
        send_event(8'd2, 8'd0, 32'd7);
        send_event(8'd3, 8'd0, 32'd8);
        send_event(8'd5, 8'd3, 32'd9);
        send_event(8'd6, 8'd3, 32'd10);
        send_event(8'd6, 8'd3, 32'd11);
        send_event(8'd5, 8'd0, 32'd12);
        drain_results;

        // Largest interval: only an elapsed time of all ones gets through.
        program_limits(32'hFFFF_FFFF, 5'd31, 32'h8000_0000, 8'd200, 8'd201, 8'd0, 8'd255);
        send_event(8'd31, 8'd0, 32'd50);
        send_event(8'd200, 8'd255, 32'd51);
        send_event(8'd201, 8'd0, 32'd52);
        send_event(8'd4, 8'd1, 32'd100);
        send_event(8'd4, 8'd1, 32'd99);
        send_event(8'd4, 8'd1, 32'd98);
        send_event(8'd4, 8'd1, 32'd98);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results;
            case (p)
                0: program_limits(32'd40, 5'd31, 32'd0, 8'd1, 8'd2, 8'd0, 8'd1);
                1: program_limits($urandom_range(400, 20), 5'd3, $urandom,
                                  8'd2, 8'd2, 8'd1, 8'd1);
                2: program_limits(32'd0, 5'd31, 32'd0, 8'd0, 8'd3, 8'd2, 8'd3);
                3: program_limits(32'hFFFF_FFFF, 5'd0, 32'd0, 8'($urandom_range(3)),
                                  8'($urandom_range(3)), 8'd3, 8'd0);
                4: program_limits(32'd1000000, 5'd31, 32'hFFFF_FFFF, 8'd255, 8'd0,
                                  8'd255, 8'd0);
                default: program_limits($urandom_range(500, 10), 5'($urandom),
                                        $urandom & $urandom, 8'($urandom_range(7)),
                                        8'($urandom_range(7)), 8'($urandom_range(5)),
                                        8'($urandom_range(5)));
            endcase
            if (p > 0) begin
                ts_now = $urandom;
            end
            // One phase runs with no idling on either side.
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 20) begin
                    hold_req = 1'b1;
                end
                if (p == 3 && n == 50) begin
                    drain_results;
                end
                send_random_item();
            end
        end

        drain_results;
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
